// ===== sv/hpg_pkg.sv =====
package hpg_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned IG_W     = 20;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned FRAC_W   = 24;  // log2 fraction bits
  localparam int unsigned POS_W    = 5;   // leading-one position of a 32-bit word
  localparam int unsigned LOG_W    = POS_W + FRAC_W;
  localparam int unsigned MANT_W   = 31;  // normalized mantissa, [2^30, 2^31)
  localparam int unsigned D_W      = 30;  // -log2(v), Q24
  localparam int unsigned GD_W     = IG_W + D_W;
  localparam int unsigned GAMMA_FRAC = 16;
  localparam int unsigned TAB_W    = 27;  // log2(255) - log2(n), Q24

  // product, normalize, squarings, exponent multiply, byte search
  localparam int unsigned LAT = 1 + 1 + FRAC_W + 1 + BYTE_W;

  localparam logic [SCALE_W-1:0] SCALE_RST     = 24'd65536;
  localparam logic [IG_W-1:0]    INV_GAMMA_RST = 20'd29789;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE        = 2'd0,
    CFG_INV_GAMMA    = 2'd1,
    CFG_ALPHA_OPAQUE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic sat;   // result forced to 255
    logic zero;  // result forced to 0
  } hpg_flags_t;

  typedef logic [TAB_W:0] dtab_t [256];

  function automatic logic [63:0] log2_q24(input logic [63:0] m);
    int unsigned p;
    logic [63:0] x;
    logic [63:0] frac;
    p = 0;
    for (int i = 1; i < 64; i++) begin
      if ((m >> i) != 64'd0) p = i;
    end
    if (p >= 30) x = m >> (p - 30);
    else x = m << (30 - p);
    frac = '0;
    for (int k = 0; k < FRAC_W; k++) begin
      x = (x * x) >> 30;
      frac = {frac[62:0], 1'b0};
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(p) << FRAC_W) | frac;
  endfunction

  // top bit marks n with log2(n) <= log2(255)
  function automatic dtab_t build_dtab();
    dtab_t t;
    logic [63:0] l255;
    logic [63:0] ln;
    l255 = log2_q24(64'd255);
    for (int n = 0; n < 256; n++) begin
      ln = log2_q24(64'(n));
      if (ln <= l255) t[n] = {1'b1, TAB_W'(l255 - ln)};
      else t[n] = '0;
    end
    return t;
  endfunction

  localparam dtab_t DTAB = build_dtab();

endpackage

// ===== sv/hpg_log2.sv =====
module hpg_log2 (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [hpg_pkg::SAMPLE_W-1:0] m_i,
  input  hpg_pkg::hpg_flags_t          flags_i,
  output logic [hpg_pkg::LOG_W-1:0]    log_o,
  output hpg_pkg::hpg_flags_t          flags_o
);

  localparam int unsigned NS = hpg_pkg::FRAC_W;

  logic [hpg_pkg::POS_W-1:0]  pos;
  logic [hpg_pkg::SAMPLE_W-1:0] shifted;

  logic [hpg_pkg::MANT_W-1:0] x_q    [NS+1];
  logic [hpg_pkg::POS_W-1:0]  pos_q  [NS+1];
  logic [hpg_pkg::FRAC_W-1:0] frac_q [NS+1];
  hpg_pkg::hpg_flags_t        fl_q   [NS+1];

  always_comb begin
    pos = '0;
    for (int i = 0; i < hpg_pkg::SAMPLE_W; i++) begin
      if (m_i[i]) pos = hpg_pkg::POS_W'(i);
    end
    shifted = m_i << (hpg_pkg::POS_W'(hpg_pkg::SAMPLE_W - 1) - pos);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= shifted[hpg_pkg::SAMPLE_W-1:1];
      pos_q[0]  <= pos;
      frac_q[0] <= '0;
      fl_q[0]   <= flags_i;
    end
  end

  // one squaring per stage yields one fraction bit
  for (genvar k = 0; k < NS; k++) begin : g_sq
    logic [2*hpg_pkg::MANT_W-1:0] sq;
    logic [hpg_pkg::MANT_W:0]     sh;

    assign sq = {{hpg_pkg::MANT_W{1'b0}}, x_q[k]} * {{hpg_pkg::MANT_W{1'b0}}, x_q[k]};
    assign sh = sq[2*hpg_pkg::MANT_W-1:hpg_pkg::MANT_W-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k+1]    <= sh[hpg_pkg::MANT_W] ? sh[hpg_pkg::MANT_W:1] : sh[hpg_pkg::MANT_W-1:0];
        frac_q[k+1] <= {frac_q[k][hpg_pkg::FRAC_W-2:0], sh[hpg_pkg::MANT_W]};
        pos_q[k+1]  <= pos_q[k];
        fl_q[k+1]   <= fl_q[k];
      end
    end
  end

  assign log_o   = {pos_q[NS], frac_q[NS]};
  assign flags_o = fl_q[NS];

endmodule

// ===== sv/hpg_search.sv =====
module hpg_search (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [hpg_pkg::GD_W-1:0]   gd_i,
  input  hpg_pkg::hpg_flags_t        flags_i,
  output logic [hpg_pkg::BYTE_W-1:0] byte_o
);

  localparam int unsigned NS  = hpg_pkg::BYTE_W;
  localparam int unsigned PAD = hpg_pkg::GD_W - hpg_pkg::TAB_W - hpg_pkg::GAMMA_FRAC;

  logic [hpg_pkg::BYTE_W-1:0] lo_q [NS];
  logic [hpg_pkg::GD_W-1:0]   gd_q [NS];
  hpg_pkg::hpg_flags_t        fl_q [NS];

  // one result bit per stage, msb first
  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam logic [hpg_pkg::BYTE_W-1:0] BIT = hpg_pkg::BYTE_W'(1 << (NS - 1 - k));
    logic [hpg_pkg::BYTE_W-1:0] lo_in;
    logic [hpg_pkg::GD_W-1:0]   gd_in;
    hpg_pkg::hpg_flags_t        fl_in;
    logic [hpg_pkg::BYTE_W-1:0] cand;
    logic [hpg_pkg::TAB_W:0]    ent;
    logic                       take;

    if (k == 0) begin : g_first
      assign lo_in = '0;
      assign gd_in = gd_i;
      assign fl_in = flags_i;
    end else begin : g_next
      assign lo_in = lo_q[k-1];
      assign gd_in = gd_q[k-1];
      assign fl_in = fl_q[k-1];
    end

    assign cand = lo_in | BIT;
    assign ent  = hpg_pkg::DTAB[cand];
    assign take = ent[hpg_pkg::TAB_W] &&
                  ({{PAD{1'b0}}, ent[hpg_pkg::TAB_W-1:0], {hpg_pkg::GAMMA_FRAC{1'b0}}} >= gd_in);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_q[k] <= take ? cand : lo_in;
        gd_q[k] <= gd_in;
        fl_q[k] <= fl_in;
      end
    end
  end

  always_comb begin
    if (fl_q[NS-1].sat) byte_o = '1;
    else if (fl_q[NS-1].zero) byte_o = '0;
    else byte_o = lo_q[NS-1];
  end

endmodule

// ===== sv/hpg_chan.sv =====
module hpg_chan (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [hpg_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [hpg_pkg::SCALE_W-1:0]  scale_i,
  input  logic [hpg_pkg::IG_W-1:0]     inv_gamma_i,
  input  logic                         force_max_i,
  output logic [hpg_pkg::BYTE_W-1:0]   byte_o
);

  localparam int unsigned PW = hpg_pkg::SAMPLE_W - 1 + hpg_pkg::SCALE_W;
  localparam logic [hpg_pkg::D_W-1:0] LOG_ONE =
    hpg_pkg::D_W'(hpg_pkg::SAMPLE_W) << hpg_pkg::FRAC_W;

  logic [PW-1:0]                prod;
  logic                         non_pos;
  hpg_pkg::hpg_flags_t          fl_d;
  logic [hpg_pkg::SAMPLE_W-1:0] prod_q;
  hpg_pkg::hpg_flags_t          fl_q;

  logic [hpg_pkg::LOG_W-1:0]    log_v;
  hpg_pkg::hpg_flags_t          log_fl;
  logic [hpg_pkg::D_W-1:0]      neg_log;
  logic [hpg_pkg::GD_W-1:0]     gd_d;
  logic [hpg_pkg::GD_W-1:0]     gd_q;
  hpg_pkg::hpg_flags_t          gd_fl_q;

  // v = x * scale as Q23.32; only v < 1.0 needs the log path
  always_comb begin
    prod    = PW'(sample_i[hpg_pkg::SAMPLE_W-2:0]) * PW'(scale_i);
    non_pos = (sample_i == '0) || sample_i[hpg_pkg::SAMPLE_W-1] || (scale_i == '0);
    fl_d.zero = !force_max_i && non_pos;
    fl_d.sat  = force_max_i ||
                (!non_pos && ((|prod[PW-1:hpg_pkg::SAMPLE_W]) || (inv_gamma_i == '0)));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod[hpg_pkg::SAMPLE_W-1:0];
      fl_q   <= fl_d;
    end
  end

  hpg_log2 u_log2 (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .m_i     (prod_q),
    .flags_i (fl_q),
    .log_o   (log_v),
    .flags_o (log_fl)
  );

  always_comb begin
    neg_log = LOG_ONE - hpg_pkg::D_W'(log_v);
    gd_d    = hpg_pkg::GD_W'(inv_gamma_i) * hpg_pkg::GD_W'(neg_log);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gd_q    <= gd_d;
      gd_fl_q <= log_fl;
    end
  end

  hpg_search u_search (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .gd_i    (gd_q),
    .flags_i (gd_fl_q),
    .byte_o  (byte_o)
  );

endmodule

// ===== sv/hdr_pixel_gamma_to_8bit_top.sv =====
// Pipeline from input transfer to result: product, normalize,
// 24 log2 squaring stages, exponent multiply, 8 byte-search stages.
// Throughput: one pixel per cycle; a stalled output freezes the whole pipeline.
// Reset: asynchronous active low; clears valid bits and loads scale = 1.0,
// inv_gamma = 1/2.2, ignore_alpha = 0. No clearing pass.
module hdr_pixel_gamma_to_8bit_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hpg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [hpg_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [hpg_pkg::SAMPLE_W-1:0] red_in_i,
  input  logic signed [hpg_pkg::SAMPLE_W-1:0] green_in_i,
  input  logic signed [hpg_pkg::SAMPLE_W-1:0] blue_in_i,
  input  logic signed [hpg_pkg::SAMPLE_W-1:0] alpha_in_i,
  input  logic                                frame_end_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [hpg_pkg::BYTE_W-1:0]          red_out_o,
  output logic [hpg_pkg::BYTE_W-1:0]          green_out_o,
  output logic [hpg_pkg::BYTE_W-1:0]          blue_out_o,
  output logic [hpg_pkg::BYTE_W-1:0]          alpha_out_o,
  output logic                                frame_end_out_o
);

  localparam int unsigned LAT = hpg_pkg::LAT;

  logic [hpg_pkg::SCALE_W-1:0] scale_q;
  logic [hpg_pkg::IG_W-1:0]    inv_gamma_q;
  logic                        ign_alpha_q;
  logic [LAT-1:0]              vld_q;
  logic [LAT-1:0]              fe_q;
  logic                        en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= hpg_pkg::SCALE_RST;
      inv_gamma_q <= hpg_pkg::INV_GAMMA_RST;
      ign_alpha_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hpg_pkg::CFG_SCALE:        scale_q     <= cfg_data_i[hpg_pkg::SCALE_W-1:0];
        hpg_pkg::CFG_INV_GAMMA:    inv_gamma_q <= cfg_data_i[hpg_pkg::IG_W-1:0];
        hpg_pkg::CFG_ALPHA_OPAQUE: ign_alpha_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fe_q <= {fe_q[LAT-2:0], frame_end_in_i};
    end
  end

  assign frame_end_out_o = fe_q[LAT-1];

  hpg_chan u_red (
    .clk_i       (clk_i),
    .en_i        (en),
    .sample_i    (red_in_i),
    .scale_i     (scale_q),
    .inv_gamma_i (inv_gamma_q),
    .force_max_i (1'b0),
    .byte_o      (red_out_o)
  );

  hpg_chan u_green (
    .clk_i       (clk_i),
    .en_i        (en),
    .sample_i    (green_in_i),
    .scale_i     (scale_q),
    .inv_gamma_i (inv_gamma_q),
    .force_max_i (1'b0),
    .byte_o      (green_out_o)
  );

  hpg_chan u_blue (
    .clk_i       (clk_i),
    .en_i        (en),
    .sample_i    (blue_in_i),
    .scale_i     (scale_q),
    .inv_gamma_i (inv_gamma_q),
    .force_max_i (1'b0),
    .byte_o      (blue_out_o)
  );

  hpg_chan u_alpha (
    .clk_i       (clk_i),
    .en_i        (en),
    .sample_i    (alpha_in_i),
    .scale_i     (scale_q),
    .inv_gamma_i (inv_gamma_q),
    .force_max_i (ign_alpha_q),
    .byte_o      (alpha_out_o)
  );

endmodule

// ===== sv/hpg_checker.sv =====
module hpg_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_we_i,
  input logic [hpg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input logic [hpg_pkg::CFG_W-1:0]           cfg_data_i,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic signed [hpg_pkg::SAMPLE_W-1:0] red_in_i,
  input logic signed [hpg_pkg::SAMPLE_W-1:0] green_in_i,
  input logic signed [hpg_pkg::SAMPLE_W-1:0] blue_in_i,
  input logic signed [hpg_pkg::SAMPLE_W-1:0] alpha_in_i,
  input logic                                frame_end_in_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [hpg_pkg::BYTE_W-1:0]          red_out_o,
  input logic [hpg_pkg::BYTE_W-1:0]          green_out_o,
  input logic [hpg_pkg::BYTE_W-1:0]          blue_out_o,
  input logic [hpg_pkg::BYTE_W-1:0]          alpha_out_o,
  input logic                                frame_end_out_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_out_o) &&
    $stable(green_out_o) && $stable(blue_out_o) && $stable(alpha_out_o) &&
    $stable(frame_end_out_o))
    else $error("stalled result changed");

  // input is held back only by a blocked output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall not caused by blocked output");

  // pipeline comes out of reset empty
  a_rst_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind hdr_pixel_gamma_to_8bit_top hpg_checker u_hpg_checker (.*);

// ===== tb/hdr_pixel_gamma_to_8bit_top_tb.sv =====
module hdr_pixel_gamma_to_8bit_top_tb;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_end;
  } pix_bytes_t;

  // log2 with 24 fraction bits by repeated squaring
  function automatic logic [63:0] log2_fix(input logic [63:0] m);
    int unsigned lead;
    logic [63:0] x;
    logic [63:0] fr;
    lead = 0;
    for (int i = 1; i < 64; i++) if ((m >> i) != 64'd0) lead = i;
    x = (lead >= 30) ? (m >> (lead - 30)) : (m << (30 - lead));
    fr = '0;
    for (int k = 0; k < 24; k++) begin
      x = (x * x) >> 30;
      fr = fr << 1;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        fr[0] = 1'b1;
      end
    end
    return (64'(lead) << 24) | fr;
  endfunction

  class gamma_scoreboard;
    logic [23:0] scale_q = 24'd65536;
    logic [19:0] inv_g = 20'd29789;
    logic        ign_alpha = 1'b0;
    pix_bytes_t  pending[$];
    int          errors = 0;

    function logic [7:0] to_byte(logic [31:0] x);
      logic [63:0] prod, d, gd, l255, ln;
      logic [7:0] lo;
      logic [7:0] cand;
      if (x == 0 || x[31] || scale_q == 0) return 8'd0;
      prod = 64'(x) * 64'(scale_q);
      if (prod >= 64'h1_0000_0000 || inv_g == 0) return 8'd255;
      d = (64'd32 << 24) - log2_fix(prod);
      gd = 64'(inv_g) * d;
      l255 = log2_fix(64'd255);
      lo = 0;
      for (int b = 7; b >= 0; b--) begin
        cand = lo | (8'd1 << b);
        ln = log2_fix(64'(cand));
        if (ln <= l255 && ((l255 - ln) << 16) >= gd) lo = cand;
      end
      return lo;
    endfunction

    function void note_pixel(logic [31:0] r, g, b, a, logic fe);
      pix_bytes_t p;
      p.red = to_byte(r);
      p.green = to_byte(g);
      p.blue = to_byte(b);
      p.alpha = ign_alpha ? 8'd255 : to_byte(a);
      p.frame_end = fe;
      pending.push_back(p);
    endfunction

    function void check_pixel(pix_bytes_t got);
      pix_bytes_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [hpg_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [hpg_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic signed [31:0] r_in = 0, g_in = 0, b_in = 0, a_in = 0;
  logic fe_in = 0;
  logic [7:0] r_out, g_out, b_out, a_out;
  logic fe_out;
  gamma_scoreboard sb = new();

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  hdr_pixel_gamma_to_8bit_top u_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .red_in_i(r_in), .green_in_i(g_in), .blue_in_i(b_in), .alpha_in_i(a_in),
    .frame_end_in_i(fe_in), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .red_out_o(r_out), .green_out_o(g_out), .blue_out_o(b_out),
    .alpha_out_o(a_out), .frame_end_out_o(fe_out)
  );

  task automatic write_reg(hpg_pkg::cfg_idx_e idx, logic [hpg_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      hpg_pkg::CFG_SCALE: sb.scale_q = val;
      hpg_pkg::CFG_INV_GAMMA: sb.inv_g = val[19:0];
      hpg_pkg::CFG_ALPHA_OPAQUE: sb.ign_alpha = val[0];
      default: ;
    endcase
  endtask

  // valid stays high across back-to-back transfers; it drops only for a gap
  task automatic send_pixel(logic [31:0] r, g, b, a, logic fe, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(7) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    r_in <= r; g_in <= g; b_in <= b; a_in <= a; fe_in <= fe;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(r, g, b, a, fe);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(32'h1_0000);
      2: return $urandom_range(32'h300);
      3: return -$urandom_range(32'h2_0000);
      default: return $urandom_range(32'h2_0000);
    endcase
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (hpg_pkg::LAT + 5) @(posedge clk);
  endtask

  // receiver: random stall per transfer, with stall-free stretches
  initial begin
    int wait_n;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_pixel({r_out, g_out, b_out, a_out, fe_out});
      if (out_stall) begin
        if (wait_n > 0) wait_n--;
        else out_stall <= 0;
      end else if (out_valid && $urandom_range(3) == 0) begin
        wait_n = $urandom_range(7);
        if (wait_n > 0) out_stall <= 1;
      end
    end
  end

  initial begin
    logic [31:0] dir[] = '{32'h0, 32'h1, 32'hFFFF, 32'h1_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'hFFFF_FFFF, 32'h8000, 32'h100};
    logic [23:0] scales[] = '{24'hFFFFFF, 24'h0, 24'h1, 24'h10000, 24'h8000};
    logic [19:0] gams[] = '{20'h0, 20'hFFFFF, 20'h10000, 20'd29789, 20'h1};
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (dir[i]) send_pixel(dir[i], dir[(i+1)%9], dir[(i+2)%9], dir[(i+3)%9],
                                i[0], 0);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(hpg_pkg::CFG_SCALE, hpg_pkg::CFG_W'(ph < 5 ? scales[ph] :
                                                     $urandom_range(24'h30000)));
      write_reg(hpg_pkg::CFG_INV_GAMMA, hpg_pkg::CFG_W'(ph < 5 ? gams[ph] :
                                                         $urandom_range(20'h30000)));
      write_reg(hpg_pkg::CFG_ALPHA_OPAQUE, hpg_pkg::CFG_W'(ph[0]));
      for (int k = 0; k < 200; k++)
        send_pixel(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                   $urandom_range(1), (k / 50) % 2 == 0);
      drain();
    end
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
